FILE: rtl/rkns_pkg.sv
`timescale 1ns / 1ps

package rkns_pkg;

  localparam int unsigned KEY_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned PH_W   = 3;
  localparam int unsigned ROT_W  = 4;
  localparam int unsigned CIDX_W = 1;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_KEY  = 1'd0;
  localparam logic [CIDX_W-1:0] REG_MODE = 1'd1;

  localparam logic [NIB_W-1:0] NIB_ZERO  = 4'h0;
  localparam logic [NIB_W-1:0] NIB_PLUS  = 4'h1;
  localparam logic [NIB_W-1:0] NIB_MINUS = 4'hF;

  // One byte waiting in the input stage, with the phase it is ciphered under.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [PH_W-1:0]   phase;
  } item_t;

  // Encrypt-direction step of the high nibble, modulo 16.
  function automatic logic [NIB_W-1:0] hi_delta(input logic [PH_W-1:0] ph);
    logic [NIB_W-1:0] d;
    case (ph) inside
      3'd0, 3'd1, 3'd7: d = NIB_MINUS;
      3'd3, 3'd4, 3'd5: d = NIB_PLUS;
      default:          d = NIB_ZERO;
    endcase
    return d;
  endfunction

  // Encrypt-direction step of the low nibble, modulo 16.
  function automatic logic [NIB_W-1:0] lo_delta(input logic [PH_W-1:0] ph);
    logic [NIB_W-1:0] d;
    case (ph) inside
      3'd1, 3'd2, 3'd3: d = NIB_PLUS;
      3'd5, 3'd6, 3'd7: d = NIB_MINUS;
      default:          d = NIB_ZERO;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/rkns_rotor.sv
`timescale 1ns / 1ps

module rkns_rotor
  import rkns_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] key,
  input  logic             adv,
  input  logic             som,
  output logic [PH_W-1:0]  phase_sel
);

  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [ROT_W-1:0] rotor_r, rotor_nxt;
  logic [ROT_W-1:0] rotor_sel;

  // A message start reseeds the phase from the key and rewinds the rotor.
  assign phase_sel = som ? key[PH_W-1:0] : phase_r;
  assign rotor_sel = som ? '0 : rotor_r;

  always_comb begin
    phase_nxt = phase_r;
    rotor_nxt = rotor_r;
    if (adv) begin
      phase_nxt = key[rotor_sel] ? phase_sel + 1'b1 : phase_sel;
      rotor_nxt = rotor_sel + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      rotor_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      rotor_r <= rotor_nxt;
    end
  end

endmodule

FILE: rtl/rkns_xform.sv
`timescale 1ns / 1ps

module rkns_xform
  import rkns_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  item_t             item,
  input  logic              encrypt,
  output logic [BYTE_W-1:0] data_out
);

  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [NIB_W-1:0]  hi, lo, dh, dl;

  always_comb begin
    dh = hi_delta(item.phase);
    dl = lo_delta(item.phase);
    // Decryption undoes the encrypt step by subtracting the same deltas.
    if (encrypt) begin
      hi = item.data[BYTE_W-1:NIB_W] + dh;
      lo = item.data[NIB_W-1:0] + dl;
    end else begin
      hi = item.data[BYTE_W-1:NIB_W] - dh;
      lo = item.data[NIB_W-1:0] - dl;
    end
    data_nxt = load ? {hi, lo} : data_r;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

FILE: rtl/rotor_keyed_nibble_shift_cipher.sv
`timescale 1ns / 1ps

// Byte stream cipher that shifts each nibble of a byte by a phase-selected
// step and steps the phase under control of a 16-bit key and a 4-bit rotor.
// Input transactions carry one byte and a start-of-message flag; a set flag
// reseeds the phase from the low three key bits and rewinds the rotor before
// that byte is ciphered. Every input transaction yields exactly one output
// transaction carrying the transformed byte.
// The configuration port writes the key (index 0) or the mode (index 1,
// where 1 encrypts and 0 decrypts). Write it only while the block is idle.
// An accepted byte passes the input register and the output register: the phase
// and rotor are advanced as a byte enters the input register, and the
// nibble step runs between the input register and the output register.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its byte and the
// input register fills; after that in_ready drops until the output drains.
// Synchronous reset clears the key, mode, phase, rotor and both valid flags.

module rotor_keyed_nibble_shift_cipher
  import rkns_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_in,
  input  logic              in_start_of_message,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_data_out
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             mode_r, mode_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic             s2_v_r, s2_v_nxt;
  item_t            s1_item_r, s1_item_nxt;
  logic             in_acc, s1_adv;
  logic [PH_W-1:0]  phase_sel;

  // Configuration registers.
  always_comb begin
    key_nxt  = key_r;
    mode_nxt = mode_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY:  key_nxt  = cfg_wdata;
        REG_MODE: mode_nxt = cfg_wdata[0];
        default:  ;
      endcase
    end
  end

  // The input stage moves on when the output register is empty or drains.
  assign s1_adv   = !s2_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  rkns_rotor u_rotor (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (key_r),
    .adv       (in_acc),
    .som       (in_start_of_message),
    .phase_sel (phase_sel)
  );

  always_comb begin
    s1_item_nxt = s1_item_r;
    if (in_acc) begin
      s1_item_nxt.data  = in_data_in;
      s1_item_nxt.phase = phase_sel;
    end
    s1_v_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    s2_v_nxt = (s1_v_r && s1_adv) ? 1'b1 : (out_ready ? 1'b0 : s2_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      mode_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      key_r  <= key_nxt;
      mode_r <= mode_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  rkns_xform u_xform (
    .clk      (clk),
    .load     (s1_v_r && s1_adv),
    .item     (s1_item_r),
    .encrypt  (mode_r),
    .data_out (out_data_out)
  );

  assign out_valid = s2_v_r;

`ifndef SYNTHESIS
  // A byte that opens a message is ciphered under the key's seed phase.
  a_som_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_start_of_message) |=> (s1_item_r.phase == $past(key_r[PH_W-1:0])))
    else $error("message start did not seed the phase from the key");

  // A full pipeline with a stalled receiver must refuse new bytes.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full");

  // A byte leaving the input stage shows up at the output next cycle.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv) |=> out_valid)
    else $error("byte lost between input and output registers");

  // An accepted byte always occupies the input stage on the next cycle.
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted byte not held in input register");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the rotor keyed nibble shift cipher.
// A driver process offers bytes from a queue that the stimulus block fills.
// A monitor process predicts each output byte when its input transaction is
// accepted and compares every output transaction against the oldest
// prediction. Key and mode are only changed while the block is drained.

module testbench;
  import rkns_pkg::*;

  // Encrypt-direction nibble steps, one nibble per phase (phase 0 in bits 3:0).
  // A value of F stands for minus one modulo 16.
  localparam logic [31:0] HI_STEPS = 32'hF011_10FF;
  localparam logic [31:0] LO_STEPS = 32'hFFF0_1110;

  // The block answers through its input and output registers; give it some slack.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_STALL    = 300;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_BYTES   = 80;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              som;
  } msg_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_data_in = '0;
  logic              in_start_of_message = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_data_out;

  // Bytes waiting to be offered, and cipher bytes waiting to come out.
  msg_byte_t         plain_q[$];
  logic [BYTE_W-1:0] cipher_q[$];

  // Our own copy of the cipher state and of the two registers.
  logic [KEY_W-1:0]  key_reg = '0;
  logic              enc_mode = 1'b0;
  logic [PH_W-1:0]   cur_phase = '0;
  logic [ROT_W-1:0]  cur_rotor = '0;

  logic in_fire = 1'b0;
  bit   idle_en = 1'b1;
  int   n_queued = 0;
  int   n_results = 0;
  int   errors = 0;

  // The stimulus block asks for a long receiver hold-off by bumping
  // rx_stall_asks; the receiver process owns the countdown.
  int   rx_stall_asks = 0;
  int   rx_stall_done = 0;
  int   rx_stall_left = 0;

  rotor_keyed_nibble_shift_cipher i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_in          (in_data_in),
    .in_start_of_message (in_start_of_message),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data_out        (out_data_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Computes the cipher byte for one accepted input byte and advances the
  // phase and rotor exactly as the block does. A message start reseeds the
  // phase from the low key bits and rewinds the rotor before the byte.
  function automatic logic [BYTE_W-1:0] cipher_next(input logic [BYTE_W-1:0] b,
                                                    input logic som);
    logic [NIB_W-1:0] hi;
    logic [NIB_W-1:0] lo;
    logic [NIB_W-1:0] dh;
    logic [NIB_W-1:0] dl;
    if (som) begin
      cur_phase = key_reg[PH_W-1:0];
      cur_rotor = '0;
    end
    hi = b[7:4];
    lo = b[3:0];
    dh = HI_STEPS[cur_phase*NIB_W +: NIB_W];
    dl = LO_STEPS[cur_phase*NIB_W +: NIB_W];
    if (enc_mode) begin
      hi = hi + dh;
      lo = lo + dl;
    end else begin
      hi = hi - dh;
      lo = lo - dl;
    end
    // The key bit under the rotor decides whether the phase moves on.
    if (key_reg[cur_rotor]) begin
      cur_phase = cur_phase + 1'b1;
    end
    cur_rotor = cur_rotor + 1'b1;
    return {hi, lo};
  endfunction

  // Monitor: everything here is sampled at the rising edge, where the
  // handshakes take effect. Predictions are made at input acceptance.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        cipher_q.push_back(cipher_next(in_data_in, in_start_of_message));
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected output transaction, expected none, actual %02h",
                   $time, out_data_out);
          errors++;
        end else if (out_data_out !== cipher_q[0]) begin
          $display("%0t: data_out mismatch, expected %02h, actual %02h",
                   $time, cipher_q[0], out_data_out);
          errors++;
          void'(cipher_q.pop_front());
        end else begin
          void'(cipher_q.pop_front());
        end
      end
    end
  end

  // Driver: a new byte goes out at the falling edge once the previous one
  // was accepted; otherwise valid and payload are left untouched.
  always @(negedge clk) begin
    msg_byte_t nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (plain_q.size() > 0 && !(idle_en && $urandom_range(99) < 10)) begin
        nb = plain_q.pop_front();
        in_valid <= 1'b1;
        in_data_in <= nb.data;
        in_start_of_message <= nb.som;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request so that
  // the block fills and has to drop in_ready.
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_stall_asks != rx_stall_done) begin
      rx_stall_done <= rx_stall_done + 1;
      rx_stall_left <= LONG_STALL;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_en && $urandom_range(99) < 10);
    end
  end

  task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic som);
    msg_byte_t nb;
    nb.data = data;
    nb.som = som;
    plain_q.push_back(nb);
    n_queued++;
  endtask

  // One message of random bytes; without a start flag it simply continues
  // whatever message state the block currently holds.
  task automatic queue_message(input int len, input bit with_start);
    for (int i = 0; i < len; i++) begin
      queue_byte(8'($urandom), with_start && (i == 0));
    end
  endtask

  // The register file of our model follows the write; the block is idle
  // whenever this is called, so no prediction can see a half-done update.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [KEY_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_KEY) begin
      key_reg = val;
    end else if (idx == REG_MODE) begin
      enc_mode = val[0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the sender back until every queued byte has come out again.
  task automatic wait_drained();
    while (n_results < n_queued) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [KEY_W-1:0] rkey;
    int               count;
    int               len;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Bytes before any message start run on the reset state: phase 0,
    // rotor 0, zero key, decrypt mode.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    wait_drained();

    // With every key bit set the phase steps on each byte, so one short
    // message walks through all eight steps; seed phase is 7.
    write_reg(REG_KEY, 16'hFFFF);
    write_reg(REG_MODE, 16'h0001);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h01, 1'b0);
    wait_drained();

    // The same walk in the decrypt direction.
    write_reg(REG_MODE, 16'h0000);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFE, 1'b0);
    wait_drained();

    // A key change in the middle of a message gates the next steps at once
    // while the phase keeps running from where it was.
    write_reg(REG_KEY, 16'h5A5A);
    queue_byte(8'h3C, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);
    wait_drained();

    // Random phases: mostly proper messages, some of them wrapping the rotor,
    // some continuing across a register change without a start flag.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) begin
        rkey = 16'h0000;
      end else if (p == 1) begin
        rkey = 16'hFFFF;
      end else begin
        rkey = 16'($urandom);
      end
      write_reg(REG_KEY, rkey);
      write_reg(REG_MODE, (p == 4) ? 16'h0001 : 16'($urandom_range(1)));
      idle_en = (p != 2);
      if (p == 3) begin
        rx_stall_asks++;
      end
      count = 0;
      while (count < PHASE_BYTES) begin
        len = $urandom_range(40, 1);
        queue_message(len, (count != 0) || (p % 2 == 1) ? ($urandom_range(9) != 0) : 1'b0);
        count += len;
      end
      wait_drained();
    end
    idle_en = 1'b1;

    repeat (10) @(negedge clk);
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("PASS rotor_keyed_nibble_shift_cipher");
    end else begin
      $display("FAIL rotor_keyed_nibble_shift_cipher");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a missing output transaction.
  initial begin
    #2000000;
    $display("FAIL rotor_keyed_nibble_shift_cipher");
    $finish;
  end

endmodule
